FILE: src/bpse_pkg.sv
// Shared types and constants for the beam power scale exponent block.
package bpse_pkg;

   localparam int LOG2_TABLE_SIZE_DEFAULT = 32;
   localparam int POWER_W = 16;
   localparam int FRAC_W = 24;
   localparam int EXP_W = 4;
   localparam int LOG_W = EXP_W + FRAC_W;
   localparam int SCALE_MAX = 15;

   typedef struct packed {
      logic [POWER_W-1:0] max_power;
      logic [POWER_W-1:0] power_log2;
   } peak_type;

   typedef struct packed {
      logic               zero;
      logic [POWER_W-1:0] power_log2;
      logic [LOG_W-1:0]   log_value;
   } log_type;

endpackage

FILE: src/bpse_if.sv
// Valid/ready channel interfaces for beam samples and scale results.
interface bpse_req_if;
   logic                         valid;
   logic                         ready;
   logic signed [7:0]            sample_real;
   logic signed [7:0]            sample_imag;
   logic [bpse_pkg::POWER_W-1:0] power_log2;
   logic                         last_beam;

   modport source (output valid, sample_real, sample_imag, power_log2, last_beam,
                   input ready);
   modport sink (input valid, sample_real, sample_imag, power_log2, last_beam,
                 output ready);
endinterface

interface bpse_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bpse_pkg::EXP_W-1:0] scale_exponent;
   logic                       scale_zero;
   logic                       out_of_range;

   modport source (output valid, scale_exponent, scale_zero, out_of_range,
                   input ready);
   modport sink (input valid, scale_exponent, scale_zero, out_of_range,
                 output ready);
endinterface

FILE: src/bpse_peak.sv
// Running maximum of sample power and capture of the cell on its last beam.
module bpse_peak (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [7:0]            sample_real,
   input  logic signed [7:0]            sample_imag,
   input  logic [bpse_pkg::POWER_W-1:0] power_log2,
   input  logic                         last_beam,
   output logic                         out_valid,
   input  logic                         out_ready,
   output bpse_pkg::peak_type           out_data
);
   import bpse_pkg::*;

   logic [POWER_W-1:0]        max_ff, max_in;
   logic                      valid_ff, valid_in;
   peak_type                  data_ff, data_in;
   logic signed [POWER_W-1:0] re_wide, im_wide;
   logic [POWER_W-1:0]        re_sq, im_sq, power, max_pick;
   logic                      accept;

   assign in_ready = !valid_ff || out_ready;
   assign accept = in_valid && in_ready;
   assign re_wide = POWER_W'(sample_real);
   assign im_wide = POWER_W'(sample_imag);
   assign re_sq = re_wide * re_wide;
   assign im_sq = im_wide * im_wide;
   assign power = re_sq + im_sq;
   assign max_pick = (power > max_ff) ? power : max_ff;

   always_comb begin
      max_in = max_ff;
      valid_in = valid_ff && !out_ready;
      data_in = data_ff;
      if (accept) begin
         max_in = last_beam ? '0 : max_pick;
         if (last_beam) begin
            valid_in = 1'b1;
            data_in.max_power = max_pick;
            data_in.power_log2 = power_log2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         max_ff <= max_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && last_beam |=> max_ff == '0)
      else $error("maximum not cleared after last beam");
   a_max_bound: assert property (@(posedge clock) disable iff (reset)
      max_ff <= POWER_W'(32768))
      else $error("maximum power out of bounds");
   a_max_monotonic: assert property (@(posedge clock) disable iff (reset)
      accept && !last_beam |=> max_ff >= $past(max_ff))
      else $error("maximum decreased within a cell");
   a_capture_holds_max: assert property (@(posedge clock) disable iff (reset)
      accept && last_beam |=> valid_ff && data_ff.max_power >= $past(max_ff))
      else $error("captured maximum below running maximum");

endmodule

FILE: src/bpse_log2.sv
// Leading-one search and table lookup forming 2^24*log2 of the maximum power.
module bpse_log2 #(
   parameter int LOG2_TABLE_SIZE = bpse_pkg::LOG2_TABLE_SIZE_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  bpse_pkg::peak_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output bpse_pkg::log_type   out_data
);
   import bpse_pkg::*;

   localparam int IDX_W = (LOG2_TABLE_SIZE > 1) ? $clog2(LOG2_TABLE_SIZE) : 1;
   localparam int SIZE_W = $clog2(LOG2_TABLE_SIZE + 1);
   localparam int PROD_W = POWER_W + SIZE_W;

   typedef logic [FRAC_W-1:0] tbl_type [LOG2_TABLE_SIZE];

   function automatic tbl_type build_table();
      tbl_type     t;
      logic [63:0] y;
      logic [63:0] res;
      logic [63:0] rnd;
      for (int i = 0; i < LOG2_TABLE_SIZE; i++) begin
         y = ((64'(LOG2_TABLE_SIZE) + 64'(i)) << 31) / 64'(LOG2_TABLE_SIZE);
         res = '0;
         for (int k = 0; k < 32; k++) begin
            y = (y * y) >> 31;
            res = res << 1;
            if (y >= (64'd2 << 31)) begin
               y = y >> 1;
               res = res | 64'd1;
            end
         end
         rnd = (res + 64'd128) >> 8;
         t[i] = rnd[FRAC_W-1:0];
      end
      return t;
   endfunction

   localparam tbl_type LogTable = build_table();

   logic               valid_ff, valid_in;
   log_type            data_ff, data_in;
   logic [EXP_W-1:0]   lead;
   logic [POWER_W-1:0] frac;
   logic [PROD_W-1:0]  scaled;
   logic [PROD_W-1:0]  shifted;
   logic [IDX_W-1:0]   idx;
   logic               load;

   assign in_ready = !valid_ff || out_ready;
   assign load = in_valid && in_ready;

   always_comb begin
      lead = '0;
      for (int b = 1; b < POWER_W; b++) begin
         if (in_data.max_power[b]) begin
            lead = EXP_W'(b);
         end
      end
   end

   assign frac = in_data.max_power - (POWER_W'(1) << lead);
   assign scaled = PROD_W'(frac) * PROD_W'(LOG2_TABLE_SIZE);
   assign shifted = scaled >> lead;
   assign idx = (shifted >= PROD_W'(LOG2_TABLE_SIZE)) ? IDX_W'(LOG2_TABLE_SIZE - 1)
                                                     : shifted[IDX_W-1:0];

   always_comb begin
      valid_in = valid_ff && !out_ready;
      data_in = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in.zero = (in_data.max_power == '0);
         data_in.power_log2 = in_data.power_log2;
         data_in.log_value = {lead, LogTable[idx]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

FILE: src/bpse_scale.sv
// Difference, rounding and range check into the result register.
module bpse_scale (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  bpse_pkg::log_type          in_data,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [bpse_pkg::EXP_W-1:0] scale_exponent,
   output logic                       scale_zero,
   output logic                       out_of_range
);
   import bpse_pkg::*;

   localparam int DIFF_W = POWER_W + 16 + 1;
   localparam int MAG_W = DIFF_W - 1;
   localparam int RND_W = MAG_W + 1 - 25;

   logic               valid_ff;
   logic [EXP_W-1:0]   exp_ff, exp_in;
   logic               zero_ff, zero_in;
   logic               oor_ff, oor_in;
   logic [DIFF_W-1:0]  diff;
   logic               neg;
   logic [MAG_W-1:0]   mag;
   logic [MAG_W:0]     biased;
   logic [RND_W-1:0]   rounded;
   logic               wide;
   logic               load;

   assign in_ready = !valid_ff || out_ready;
   assign load = in_valid && in_ready;

   assign diff = {1'b0, in_data.power_log2, 16'd0} - DIFF_W'(in_data.log_value);
   assign neg = diff[DIFF_W-1];
   assign mag = neg ? MAG_W'(-diff) : diff[MAG_W-1:0];
   assign biased = {1'b0, mag} + (MAG_W+1)'(1 << 24);
   assign rounded = biased[MAG_W:25];
   assign wide = (rounded > RND_W'(SCALE_MAX)) || (neg && rounded != '0);

   always_comb begin
      zero_in = in_data.zero;
      oor_in = !in_data.zero && wide;
      exp_in = (in_data.zero || wide) ? '0 : rounded[EXP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         exp_ff <= exp_in;
         zero_ff <= zero_in;
         oor_ff <= oor_in;
      end
   end

   assign out_valid = valid_ff;
   assign scale_exponent = exp_ff;
   assign scale_zero = zero_ff;
   assign out_of_range = oor_ff;

endmodule

FILE: src/beam_power_scale_exponent.sv
// Top level: beam power scale exponent, peak capture, log2 and scale stages.
//
//  channel  dir  handshake            payload
//  req_bus  in   valid/ready          sample_real, sample_imag, power_log2, last_beam
//  rsp_bus  out  valid/ready          scale_exponent, scale_zero, out_of_range
//
//  One transaction per cycle on req_bus while ready; non-last beams only update the max.
//  A last-beam transaction's result passes through the peak, log2 and scale registers.
//  Reset clears the running maximum and all stage valid flags.
//  Each stage holds while the next one is full and stalled; req_bus.ready drops only
//  when all three stages hold a transaction and rsp_bus.ready is low.
module beam_power_scale_exponent #(
   parameter int LOG2_TABLE_SIZE = bpse_pkg::LOG2_TABLE_SIZE_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   bpse_req_if.sink  req_bus,
   bpse_rsp_if.source rsp_bus
);
   import bpse_pkg::*;

   peak_type peak_data;
   log_type  log_data;
   logic     peak_valid, peak_ready;
   logic     log_valid, log_ready;

   bpse_peak u_peak (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_bus.valid),
      .in_ready    (req_bus.ready),
      .sample_real (req_bus.sample_real),
      .sample_imag (req_bus.sample_imag),
      .power_log2  (req_bus.power_log2),
      .last_beam   (req_bus.last_beam),
      .out_valid   (peak_valid),
      .out_ready   (peak_ready),
      .out_data    (peak_data)
   );

   bpse_log2 #(
      .LOG2_TABLE_SIZE (LOG2_TABLE_SIZE)
   ) u_log2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (peak_valid),
      .in_ready  (peak_ready),
      .in_data   (peak_data),
      .out_valid (log_valid),
      .out_ready (log_ready),
      .out_data  (log_data)
   );

   bpse_scale u_scale (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (log_valid),
      .in_ready       (log_ready),
      .in_data        (log_data),
      .out_valid      (rsp_bus.valid),
      .out_ready      (rsp_bus.ready),
      .scale_exponent (rsp_bus.scale_exponent),
      .scale_zero     (rsp_bus.scale_zero),
      .out_of_range   (rsp_bus.out_of_range)
   );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for beam_power_scale_exponent: beam samples in, scale exponents out.
module tb;
   import bpse_pkg::*;

   localparam int LOG2_ENTRIES = LOG2_TABLE_SIZE_DEFAULT;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_BEAMS = 800;

   typedef struct {
      logic [EXP_W-1:0] exponent;
      logic             zero;
      logic             oor;
   } scale_result_type;

   logic clock;
   logic reset;

   bpse_req_if req_bus ();
   bpse_rsp_if rsp_bus ();

   beam_power_scale_exponent #(
      .LOG2_TABLE_SIZE(LOG2_ENTRIES)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   logic [31:0]      log2_rom [LOG2_ENTRIES];
   int unsigned      peak_power;
   scale_result_type pending_scales[$];
   scale_result_type want;

   int errors;
   int cycle_count;
   int beams_sent;
   int cells_sent;
   int results_seen;
   int zero_seen;
   int oor_seen;
   int hold_request;
   int burst_left;
   bit steady_feed;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int msb_index(input int unsigned v);
      for (int b = POWER_W - 1; b > 0; b--) begin
         if (v[b]) return b;
      end
      return 0;
   endfunction

   // 2^24 * log2(1 + idx/N), bit-serial squaring in Q31
   function automatic void build_log2_rom();
      logic [63:0] y;
      logic [63:0] acc;
      for (int idx = 0; idx < LOG2_ENTRIES; idx++) begin
         y   = (64'(LOG2_ENTRIES + idx) << 31) / 64'(LOG2_ENTRIES);
         acc = '0;
         for (int k = 0; k < 32; k++) begin
            y   = (y * y) >> 31;
            acc = acc << 1;
            if (y >= (64'd2 << 31)) begin
               y      = y >> 1;
               acc[0] = 1'b1;
            end
         end
         log2_rom[idx] = 32'((acc + 64'd128) >> 8);
      end
   endfunction

   function automatic scale_result_type scale_from_peak(input int unsigned peak,
                                                        input logic [POWER_W-1:0] ref_power);
      scale_result_type res;
      int               e;
      int unsigned      idx;
      longint           d;
      longint           r;
      res = '{exponent: '0, zero: 1'b0, oor: 1'b0};
      if (peak == 0) begin
         res.zero = 1'b1;
         return res;
      end
      e   = msb_index(peak);
      idx = ((peak - (32'd1 << e)) * LOG2_ENTRIES) >> e;
      if (idx >= LOG2_ENTRIES) idx = LOG2_ENTRIES - 1;
      d = (longint'(ref_power) <<< 16) - ((longint'(e) <<< 24) + longint'(log2_rom[idx]));
      if (d >= 0) r = (d + (64'sd1 <<< 24)) >>> 25;
      else r = -((-d + (64'sd1 <<< 24)) >>> 25);
      if (r >= 0 && r <= SCALE_MAX) res.exponent = EXP_W'(r);
      else res.oor = 1'b1;
      return res;
   endfunction

   function automatic void track_beam_peak(input logic signed [7:0] re,
                                           input logic signed [7:0] im,
                                           input logic [POWER_W-1:0] ref_power,
                                           input logic last);
      int unsigned p;
      p = int'(re) * int'(re) + int'(im) * int'(im);
      if (p > peak_power) peak_power = p;
      if (last) begin
         pending_scales.push_back(scale_from_peak(peak_power & 32'hFFFF, ref_power));
         peak_power = 0;
      end
   endfunction

   task automatic send_beam(input logic signed [7:0] re, input logic signed [7:0] im,
                            input logic [POWER_W-1:0] ref_power, input logic last);
      int gap;
      if (!steady_feed) begin
         if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            repeat (gap) begin
               @(negedge clock);
               req_bus.valid = 1'b0;
            end
         end
         burst_left--;
      end
      @(negedge clock);
      req_bus.sample_real = re;
      req_bus.sample_imag = im;
      req_bus.power_log2  = ref_power;
      req_bus.last_beam   = last;
      req_bus.valid       = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      track_beam_peak(re, im, ref_power, last);
      beams_sent++;
      if (last) cells_sent++;
   endtask

   task automatic stop_feeding();
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic wait_for_scales();
      while (pending_scales.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_random_cell();
      int                 len;
      int                 kind;
      int                 e;
      int                 target;
      int unsigned        peak;
      int unsigned        p;
      logic signed [7:0]  re;
      logic signed [7:0]  im;
      logic [POWER_W-1:0] pwr;
      case ($urandom_range(0, 9))
         0: len = 1;
         1, 2: len = $urandom_range(7, 20);
         default: len = $urandom_range(1, 6);
      endcase
      kind = $urandom_range(0, 3);
      peak = 0;
      for (int i = 0; i < len; i++) begin
         case (kind)
            1: begin
               re = 8'($signed($urandom_range(0, 8)) - 4);
               im = 8'($signed($urandom_range(0, 8)) - 4);
            end
            2: begin
               re = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'sd0;
               im = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'sd0;
            end
            default: begin
               re = 8'($urandom);
               im = 8'($urandom);
            end
         endcase
         p = int'(re) * int'(re) + int'(im) * int'(im);
         if (p > peak) peak = p;
         pwr = POWER_W'($urandom);
         if (i == len - 1 && peak != 0 && $urandom_range(0, 4) != 0) begin
            // aim near the centre of each scale step
            e      = msb_index(peak);
            target = e * 256 + int'(((peak - (32'd1 << e)) * 256) >> e)
                     + (int'($urandom_range(0, 19)) - 2) * 512
                     + int'($urandom_range(0, 64)) - 32;
            if (target < 0) target = 0;
            if (target > 65535) target = 65535;
            pwr = POWER_W'(target);
         end
         send_beam(re, im, pwr, i == len - 1);
      end
   endtask

   task automatic test_zero_cells();
      send_beam(8'sd0, 8'sd0, 16'h0000, 1'b1);
      send_beam(8'sd0, 8'sd0, 16'hFFFF, 1'b0);
      send_beam(8'sd0, 8'sd0, 16'h1234, 1'b1);
   endtask

   task automatic test_extremes();
      send_beam(-8'sd128, -8'sd128, 16'd3840, 1'b1);
      send_beam(-8'sd128, -8'sd128, 16'd11520, 1'b1);
      send_beam(-8'sd128, -8'sd128, 16'h0000, 1'b1);
      send_beam(-8'sd128, -8'sd128, 16'hFFFF, 1'b1);
      send_beam(8'sd127, 8'sd127, 16'h8000, 1'b1);
      send_beam(8'sd127, -8'sd128, 16'h5555, 1'b1);
      send_beam(-8'sd128, 8'sd127, 16'hAAAA, 1'b1);
   endtask

   task automatic test_rounding();
      send_beam(8'sd1, 8'sd0, 16'd256, 1'b1);
      send_beam(8'sd0, -8'sd1, 16'd255, 1'b1);
      send_beam(-8'sd1, 8'sd0, 16'd0, 1'b1);
      send_beam(-8'sd128, -8'sd128, 16'd3584, 1'b1);
      send_beam(-8'sd128, -8'sd128, 16'd11775, 1'b1);
      send_beam(-8'sd128, -8'sd128, 16'd11776, 1'b1);
   endtask

   task automatic test_multi_beam_cells();
      send_beam(8'sd3, 8'sd4, 16'hFFFF, 1'b0);
      send_beam(-8'sd128, 8'sd0, 16'h0000, 1'b0);
      send_beam(8'sd5, 8'sd5, 16'd4000, 1'b1);
      send_beam(8'sd1, 8'sd1, 16'h0F0F, 1'b0);
      send_beam(8'sd2, -8'sd2, 16'hF0F0, 1'b0);
      send_beam(-8'sd100, 8'sd90, 16'd6000, 1'b1);
   endtask

   task automatic test_random_cells();
      while (beams_sent < RANDOM_BEAMS) send_random_cell();
   endtask

   task automatic test_backpressure();
      hold_request = 80;
      steady_feed  = 1'b1;
      repeat (20) send_beam(8'($urandom), 8'($urandom), POWER_W'($urandom), 1'b1);
      steady_feed = 1'b0;
      stop_feeding();
      wait_for_scales();
   endtask

   task automatic test_pause_between_cells();
      repeat (6) begin
         send_random_cell();
         stop_feeding();
         wait_for_scales();
      end
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         int pattern_left;
         int ready_pct;
         int hold_left;
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else begin
            if (pattern_left == 0) begin
               case ($urandom_range(0, 4))
                  0, 1: ready_pct = 100;
                  2: ready_pct = 75;
                  3: ready_pct = 50;
                  default: ready_pct = 20;
               endcase
               pattern_left = $urandom_range(5, 60);
            end
            pattern_left--;
            rsp_bus.ready = ($urandom_range(0, 99) < ready_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (rsp_bus.scale_zero) zero_seen++;
         if (rsp_bus.out_of_range) oor_seen++;
         if (pending_scales.size() == 0) begin
            $error("scale result with none pending: exponent %0d zero %0b oor %0b",
                   rsp_bus.scale_exponent, rsp_bus.scale_zero, rsp_bus.out_of_range);
            errors++;
         end else begin
            want = pending_scales.pop_front();
            if (rsp_bus.scale_exponent !== want.exponent) begin
               $error("scale_exponent: expected %0d, got %0d", want.exponent,
                      rsp_bus.scale_exponent);
               errors++;
            end
            if (rsp_bus.scale_zero !== want.zero) begin
               $error("scale_zero: expected %0b, got %0b", want.zero, rsp_bus.scale_zero);
               errors++;
            end
            if (rsp_bus.out_of_range !== want.oor) begin
               $error("out_of_range: expected %0b, got %0b", want.oor, rsp_bus.out_of_range);
               errors++;
            end
         end
      end
   end

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.sample_real = '0;
      req_bus.sample_imag = '0;
      req_bus.power_log2  = '0;
      req_bus.last_beam   = 1'b0;
      build_log2_rom();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_zero_cells();
      test_extremes();
      test_rounding();
      test_multi_beam_cells();
      test_random_cells();
      test_backpressure();
      test_pause_between_cells();

      stop_feeding();
      wait_for_scales();
      if (pending_scales.size() != 0) begin
         $error("%0d scale results never arrived", pending_scales.size());
         errors++;
      end
      repeat (8) @(posedge clock);
      $display("Sent %0d beam samples in %0d cells; checked %0d scale results", beams_sent,
               cells_sent, results_seen);
      $display("of which %0d zero peak and %0d out of range, with output stalls and holds",
               zero_seen, oor_seen);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/bpse_pkg.sv
src/bpse_if.sv
src/bpse_peak.sv
src/bpse_log2.sv
src/bpse_scale.sv
src/beam_power_scale_exponent.sv
dv/tb.sv
